// ----- design/pce_pkg.sv -----
// Shared types and constants of the palette color effect engine.
`timescale 1ns / 1ps
package pce_pkg;

  localparam int PaletteEntries = 256;
  localparam int IdxW           = $clog2(PaletteEntries);
  localparam int CntW           = $clog2(PaletteEntries + 1);
  localparam int RgbW           = 24;
  localparam int CfgW           = 9;
  localparam int CfgIdxW        = 3;
  localparam int QDepth         = 2;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_TINT     = 3'd1,
    MODE_COLORIZE = 3'd2,
    MODE_BRIGHTEN = 3'd3,
    MODE_DARKEN   = 3'd4,
    MODE_MIX      = 3'd5,
    MODE_NEGATIVE = 3'd6,
    MODE_TRANSP   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_PAINT  = 3'd1,
    REG_ERASE  = 3'd2,
    REG_AMOUNT = 3'd3,
    REG_COUNT  = 3'd4
  } reg_idx_t;

  // Classified transaction handed from the front part to the back part.
  // Loads travel through the same queue so they stay in order with pixels.
  typedef struct packed {
    logic            load;       // palette load, no result
    logic            direct;     // result is sel index, no search
    logic [IdxW-1:0] sel;
    logic [IdxW-1:0] canvas;
    logic [RgbW-1:0] ref_rgb;
    logic [IdxW-1:0] slot;
    logic [RgbW-1:0] rgb;
  } job_t;

endpackage

// ----- design/palette_color_effect_engine.sv -----
// Top level of the palette color effect engine.
`timescale 1ns / 1ps
//  channel  | direction | handshake         | payload
//  in_      | input     | in_valid/in_stall | cmd, slot, rgb, erase, canvas, reference
//  out_     | output    | out_valid/out_stall | write_pixel, new_index
//  cfg_     | input     | cfg_we            | cfg_index, cfg_data
// Every transaction passes the job queue; a load is written to the palette
// memory when the back part takes it from the queue while idle, in order with pixels.
// A direct pixel needs no search. A searched pixel reads the palette memory once
// per entry up to the palette count, and tint and colorize first pass through the
// divider; a colorize pixel that is skipped goes to the output without a search.
// Reset is synchronous and active low; palette contents stay undefined.
// A two-entry job queue lets the input side run while the back part works
// or while a result waits under out_stall.
module palette_color_effect_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_palette_slot,
  input  logic [23:0] in_palette_rgb,
  input  logic        in_use_erase,
  input  logic [7:0]  in_canvas_index,
  input  logic [23:0] in_reference_rgb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_pixel,
  output logic [7:0]  out_new_index,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import pce_pkg::*;

  logic [2:0] mode_r;
  logic [7:0] paint_r, erase_r;
  logic [6:0] amt_r;
  logic [8:0] cnt_r;
  logic       job_valid, job_take;
  job_t       job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      paint_r <= 8'd1;
      erase_r <= 8'd0;
      amt_r   <= 7'd50;
      cnt_r   <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r  <= cfg_data[2:0];
        REG_PAINT:  paint_r <= cfg_data[7:0];
        REG_ERASE:  erase_r <= cfg_data[7:0];
        REG_AMOUNT: amt_r   <= cfg_data[6:0];
        REG_COUNT:  cnt_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  pce_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_palette_slot, .in_palette_rgb,
    .in_use_erase, .in_canvas_index, .in_reference_rgb,
    .mode(mode_r), .paint_idx(paint_r), .erase_idx(erase_r),
    .job_valid, .job_take, .job
  );

  // The back part writes loads and works on pixels in the order they were accepted.
  pce_back u_back (
    .clk, .rst_n,
    .job_valid, .job_take, .job,
    .mode(mode_r), .amount(amt_r), .pcount(cnt_r),
    .out_valid, .out_stall, .out_write_pixel, .out_new_index
  );
endmodule

// ----- design/pce_front.sv -----
// Front part: accepts transactions, classifies them and queues them in order.
`timescale 1ns / 1ps
module pce_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [pce_pkg::IdxW-1:0] in_palette_slot,
  input  logic [pce_pkg::RgbW-1:0] in_palette_rgb,
  input  logic                 in_use_erase,
  input  logic [pce_pkg::IdxW-1:0] in_canvas_index,
  input  logic [pce_pkg::RgbW-1:0] in_reference_rgb,
  input  logic [2:0]           mode,
  input  logic [pce_pkg::IdxW-1:0] paint_idx,
  input  logic [pce_pkg::IdxW-1:0] erase_idx,
  output logic                 job_valid,
  input  logic                 job_take,
  output pce_pkg::job_t        job
);
  import pce_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  job_t             q_r [QDepth];
  logic [PtrW-1:0]  wp_r, rp_r;
  logic [PtrW:0]    cnt_r;
  logic             push;
  job_t             nj;

  assign in_stall  = (cnt_r == QDepth[PtrW:0]);
  assign push      = in_valid && !in_stall;
  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rp_r];

  always_comb begin
    nj.load    = !in_cmd;
    nj.slot    = in_palette_slot;
    nj.rgb     = in_palette_rgb;
    nj.sel     = in_use_erase ? erase_idx : paint_idx;
    nj.canvas  = in_canvas_index;
    nj.ref_rgb = in_reference_rgb;
    nj.direct  = (mode == MODE_NORMAL) || (in_use_erase && mode != MODE_TRANSP);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= nj;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (job_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, job_take};
    end
  end
endmodule

// ----- design/pce_back.sv -----
// Back part: palette writes, target color computation and nearest palette search.
`timescale 1ns / 1ps
module pce_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_take,
  input  pce_pkg::job_t        job,
  input  logic [2:0]           mode,
  input  logic [6:0]           amount,
  input  logic [pce_pkg::CntW-1:0] pcount,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_write_pixel,
  output logic [pce_pkg::IdxW-1:0] out_new_index
);
  import pce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDP, S_RDC, S_LATCH, S_PREP, S_DIV, S_FIN, S_SRCH, S_LAST, S_OUT
  } state_t;

  logic [RgbW-1:0] mem [PaletteEntries];
  logic [RgbW-1:0] rd_r;
  logic [IdxW-1:0] raddr;
  logic            ld_en;

  state_t          st_r, st_nxt;
  job_t            job_r;
  logic [CntW-1:0] n_r;
  logic [RgbW-1:0] p_r, c_r, t_r;
  logic [2:0]      mode_r;
  logic [6:0]      amt_r;
  logic            wp_r;
  logic [IdxW-1:0] res_r;
  // divider: three channel numerators / common denominator, 1 bit per cycle
  logic [15:0]     num_r [3];
  logic [16:0]     rem_r [3];
  logic [15:0]     quo_r [3];
  logic [15:0]     den_r;
  logic [4:0]      dcnt_r;
  // brighten/darken operands
  logic [23:0]     yv_r, stp_r;
  // search
  logic [CntW-1:0] i_r;
  logic [IdxW-1:0] best_r;
  logic [17:0]     bestd_r;
  logic            first_r;
  logic [CntW-1:0] si_r;
  logic            sv_r;

  function automatic logic [7:0] ch(input logic [RgbW-1:0] c, input int k);
    ch = c[8*(2-k) +: 8];
  endfunction
  function automatic logic [7:0] ad(input logic [7:0] a, input logic [7:0] b);
    ad = (a > b) ? a - b : b - a;
  endfunction
  function automatic logic [7:0] mx(input logic [RgbW-1:0] c);
    logic [7:0] m;
    m = c[23:16];
    if (c[15:8] > m) m = c[15:8];
    if (c[7:0] > m) m = c[7:0];
    mx = m;
  endfunction
  function automatic logic [7:0] luma(input logic [RgbW-1:0] c);
    logic [17:0] s;
    s = 18'(c[23:16]) * 18'd77 + 18'(c[15:8]) * 18'd150 + 18'(c[7:0]) * 18'd29;
    luma = s[15:8];
  endfunction

  // Palette memory: loads are written when the back part takes them; registered read.
  assign ld_en = job_take && job.load;

  always_ff @(posedge clk) begin
    if (ld_en) mem[job.slot] <= job.rgb;
    rd_r <= mem[raddr];
  end

  always_comb begin
    raddr = i_r[IdxW-1:0];
    if (st_r == S_IDLE) raddr = job.sel;
    else if (st_r == S_RDP) raddr = job_r.canvas;
  end

  assign job_take  = (st_r == S_IDLE) && job_valid;
  assign out_valid = (st_r == S_OUT);
  assign out_write_pixel = wp_r;
  assign out_new_index   = res_r;

  logic [17:0] sqd;
  logic [7:0]  e0, e1, e2;
  always_comb begin
    e0 = ad(t_r[23:16], rd_r[23:16]);
    e1 = ad(t_r[15:8], rd_r[15:8]);
    e2 = ad(t_r[7:0], rd_r[7:0]);
    sqd = 18'(e0) * 18'(e0) + 18'(e1) * 18'(e1) + 18'(e2) * 18'(e2);
  end

  logic [7:0] lp, pv;
  logic [16:0] rtry [3];
  always_comb begin
    lp = luma(p_r);
    pv = mx(p_r);
    for (int k = 0; k < 3; k++) begin
      rtry[k] = {rem_r[k][15:0], num_r[k][15]};
    end
  end

  // Grey for brighten/darken. The step amount*255*65536/100 (rounded) is split
  // into amount*167116 plus a small remainder term divided by 100 through a
  // reciprocal multiply (5243 / 2^19), which is exact over this range.
  logic [23:0] yv, stp, vb;
  logic [12:0] sfr;
  logic [25:0] sfp;
  logic [24:0] sum;
  logic [8:0]  gr;
  always_comb begin
    yv  = 24'(job_r.ref_rgb[23:16]) * 24'd13933 + 24'(job_r.ref_rgb[15:8]) * 24'd46871
        + 24'(job_r.ref_rgb[7:0]) * 24'd4732;
    sfr = 13'(amt_r) * 13'd80 + 13'd50;
    sfp = 26'(sfr) * 26'd5243;
    stp = 24'(amt_r) * 24'd167116 + 24'(sfp[25:19]);
    if (mode_r == MODE_BRIGHTEN) begin
      sum = 25'(yv_r) + 25'(stp_r);
      vb  = (sum > 25'h0FF0000) ? 24'hFF0000 : sum[23:0];
    end else begin
      sum = '0;
      vb = (yv_r > stp_r) ? yv_r - stp_r : 24'd0;
    end
    gr = 9'((25'(vb) + 25'd32768) >> 16);
    if (gr > 9'd255) gr = 9'd255;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (job_valid && !job.load) st_nxt = S_RDP;
      S_RDP:   st_nxt = S_RDC;
      S_RDC:   st_nxt = S_LATCH;
      S_LATCH: st_nxt = job_r.direct ? S_OUT : S_PREP;
      S_PREP:  st_nxt = (mode_r == MODE_TINT || mode_r == MODE_COLORIZE) ? S_DIV : S_FIN;
      S_DIV:   if (dcnt_r == 5'd15) st_nxt = S_FIN;
      S_FIN:   st_nxt = wp_r ? S_SRCH : S_OUT;
      S_SRCH:  if (!sv_r && i_r == n_r) st_nxt = S_LAST;
      S_LAST:  st_nxt = S_OUT;
      S_OUT:   if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    unique case (st_r)
      S_IDLE: begin
        job_r  <= job;
        mode_r <= mode;
        amt_r  <= (amount > 7'd100) ? 7'd100 : amount;
        n_r    <= (pcount == '0) ? CntW'(1)
                : (pcount > CntW'(PaletteEntries)) ? CntW'(PaletteEntries) : pcount;
        wp_r   <= 1'b1;
        res_r  <= job.sel;
      end
      S_RDP: p_r <= (CntW'(job_r.sel) < n_r) ? rd_r : '0;
      S_RDC: c_r <= (CntW'(job_r.canvas) < n_r) ? rd_r : '0;
      S_LATCH: ;
      S_PREP: begin
        dcnt_r <= '0;
        yv_r   <= yv;
        stp_r  <= stp;
        for (int k = 0; k < 3; k++) rem_r[k] <= '0;
        unique case (mode_r)
          MODE_TINT: begin
            den_r <= {8'd0, (lp == 8'd0) ? 8'd1 : lp};
            for (int k = 0; k < 3; k++) num_r[k] <= 16'(ch(p_r, k)) * 16'(luma(c_r));
          end
          MODE_COLORIZE: begin
            den_r <= {8'd0, (pv == 8'd0) ? 8'd1 : pv};
            for (int k = 0; k < 3; k++) num_r[k] <= 16'(ch(p_r, k)) * 16'(mx(c_r));
            if (mx(c_r) == 8'd0 || (ad(c_r[23:16], c_r[15:8]) < 8'd8 &&
                ad(c_r[15:8], c_r[7:0]) < 8'd8)) begin
              wp_r  <= 1'b0;
              res_r <= '0;
            end
          end
          MODE_TRANSP: begin
            den_r <= 16'd100;
            for (int k = 0; k < 3; k++) begin
              num_r[k] <= 16'(ch(p_r, k)) * 16'(amt_r)
                        + 16'(ch(c_r, k)) * 16'(7'd100 - amt_r);
            end
          end
          default: begin
            den_r <= 16'd1;
            for (int k = 0; k < 3; k++) num_r[k] <= '0;
          end
        endcase
      end
      S_DIV: begin
        dcnt_r <= dcnt_r + 5'd1;
        for (int k = 0; k < 3; k++) begin
          num_r[k] <= {num_r[k][14:0], 1'b0};
          if (rtry[k] >= {1'b0, den_r}) begin
            rem_r[k] <= rtry[k] - {1'b0, den_r};
            quo_r[k] <= {quo_r[k][14:0], 1'b1};
          end else begin
            rem_r[k] <= rtry[k];
            quo_r[k] <= {quo_r[k][14:0], 1'b0};
          end
        end
      end
      S_FIN: begin
        i_r     <= '0;
        sv_r    <= 1'b0;
        first_r <= 1'b1;
        unique case (mode_r)
          MODE_TINT, MODE_COLORIZE: begin
            for (int k = 0; k < 3; k++) begin
              t_r[8*(2-k) +: 8] <= (quo_r[k] > 16'd255) ? 8'd255 : quo_r[k][7:0];
            end
          end
          MODE_TRANSP: begin
            // Blend sum divided by 100 through the reciprocal 5243 / 2^19.
            for (int k = 0; k < 3; k++) begin
              t_r[8*(2-k) +: 8] <= 8'((28'(num_r[k]) * 28'd5243) >> 19);
            end
          end
          MODE_BRIGHTEN, MODE_DARKEN: t_r <= {3{gr[7:0]}};
          MODE_MIX: begin
            for (int k = 0; k < 3; k++) begin
              t_r[8*(2-k) +: 8] <= 8'((9'(ch(p_r, k)) + 9'(ch(c_r, k))) >> 1);
            end
          end
          default: t_r <= ~c_r;
        endcase
      end
      S_SRCH, S_LAST: begin
        // address i_r issued now, data for si_r compared now
        if (st_r == S_SRCH && i_r != n_r) begin
          i_r <= i_r + 1'b1;
          sv_r <= 1'b1;
        end else begin
          sv_r <= 1'b0;
        end
        si_r <= i_r;
        if (sv_r && (first_r || sqd < bestd_r)) begin
          first_r <= 1'b0;
          bestd_r <= sqd;
          best_r  <= si_r[IdxW-1:0];
        end
        if (st_r == S_LAST) res_r <= (sv_r && (first_r || sqd < bestd_r))
                                     ? si_r[IdxW-1:0] : best_r;
      end
      S_OUT: ;
      default: ;
    endcase
  end
endmodule
